FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion helper macros
// implication checks, same-cycle and next-cycle, reset-qualified
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

FILE: src/dge_pkg.sv
// ---------------------------------------------------------------------------
// dge_pkg
// shared widths, constants and types of the double gaussian evaluator
// ---------------------------------------------------------------------------
package dge_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int FRAC_BITS      = 16;
    localparam int SIGMA_BITS     = VALUE_BITS - 1;
    localparam int CFG_INDEX_BITS = 4;

    // normalised distance z = |t - x| / sigma, unsigned Q3.28
    localparam int Z_INT_BITS  = 3;
    localparam int Z_FRAC_BITS = 28;
    localparam int Z_BITS      = Z_INT_BITS + Z_FRAC_BITS;
    localparam int REM_BITS    = VALUE_BITS + 1;

    // u = z*z/2 as Q.32
    localparam int U_SHIFT = 2 * Z_FRAC_BITS - 31;
    localparam int U_BITS  = 2 * Z_BITS - U_SHIFT;

    // range reduction u = k*ln2 + r: reciprocal estimate of k, then one correction
    localparam int K_BITS     = 6;
    localparam int RED_STAGES = 3;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam int KU_SHIFT       = 16;
    localparam int KU_BITS        = U_BITS - KU_SHIFT;
    localparam int RECIP_LN2_BITS = 17;
    localparam logic [RECIP_LN2_BITS-1:0] RECIP_LN2 =
        RECIP_LN2_BITS'((64'd1 << (32 + KU_SHIFT)) / 64'(LN2_Q32));

    localparam int E_BITS       = 33;
    localparam int TAYLOR_TERMS = 12;
    localparam logic [E_BITS-1:0] ONE_Q32 = 33'h1_0000_0000;

    localparam int TERM_BITS = VALUE_BITS + 1;
    localparam int SUM_BITS  = VALUE_BITS + 2;

    // per-peak pipeline: diff, abs, divider, square, reduction, series, scale
    localparam int PEAK_LAT = 2 + Z_BITS + 1 + RED_STAGES + 3 * TAYLOR_TERMS + 3;
    localparam int PIPE_LAT = PEAK_LAT + 1;

    localparam logic [VALUE_BITS-1:0] ONE_VAL = VALUE_BITS'(64'd1 << FRAC_BITS);

    localparam logic [VALUE_BITS-1:0] RST_BASELINE_OFFSET = '0;
    localparam logic [VALUE_BITS-1:0] RST_ONE_AMPLITUDE   = ONE_VAL;
    localparam logic [VALUE_BITS-1:0] RST_ONE_CENTER      = '0;
    localparam logic [SIGMA_BITS-1:0] RST_ONE_SIGMA       = SIGMA_BITS'(ONE_VAL);
    localparam logic [VALUE_BITS-1:0] RST_TWO_AMPLITUDE   = ONE_VAL >> 1;
    localparam logic [VALUE_BITS-1:0] RST_TWO_CENTER      = ONE_VAL << 1;
    localparam logic [SIGMA_BITS-1:0] RST_TWO_SIGMA       = SIGMA_BITS'(ONE_VAL);
    localparam logic [1:0]            RST_COMPONENT_SEL   = 2'd0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BASELINE_OFFSET    = 4'd0,
        REG_PEAK_ONE_AMPLITUDE = 4'd1,
        REG_PEAK_ONE_CENTER    = 4'd2,
        REG_PEAK_ONE_SIGMA     = 4'd3,
        REG_PEAK_TWO_AMPLITUDE = 4'd4,
        REG_PEAK_TWO_CENTER    = 4'd5,
        REG_PEAK_TWO_SIGMA     = 4'd6,
        REG_COMPONENT_SELECT   = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [SIGMA_BITS-1:0] sigma;
        logic                  far;
    } div_side_t;

    typedef struct packed {
        logic [31:0]       r;
        logic [K_BITS-1:0] k;
        logic              far;
    } series_side_t;

endpackage

FILE: src/dge_in_if.sv
// ---------------------------------------------------------------------------
// dge_in_if
// sample channel: one abscissa per transaction
// ---------------------------------------------------------------------------
interface dge_in_if import dge_pkg::*; ();

    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] abscissa;

    modport source (output valid, output abscissa, input ready);
    modport sink (input valid, input abscissa, output ready);

endinterface

FILE: src/dge_out_if.sv
// ---------------------------------------------------------------------------
// dge_out_if
// result channel: model value and saturation flag per transaction
// ---------------------------------------------------------------------------
interface dge_out_if import dge_pkg::*; ();

    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] model_value;
    logic                         saturated;

    modport source (output valid, output model_value, output saturated, input ready);
    modport sink (input valid, input model_value, input saturated, output ready);

endinterface

FILE: src/dge_cfg_if.sv
// ---------------------------------------------------------------------------
// dge_cfg_if
// register write channel: index and data per transaction
// ---------------------------------------------------------------------------
interface dge_cfg_if import dge_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [VALUE_BITS-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);

endinterface

FILE: src/dge_peak.sv
// ---------------------------------------------------------------------------
// dge_peak
// one gaussian term A*exp(-0.5*((t-x)/s)^2), fully pipelined
// ---------------------------------------------------------------------------
module dge_peak import dge_pkg::*; (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [VALUE_BITS-1:0] abscissa,
    input  logic signed [VALUE_BITS-1:0] center,
    input  logic        [SIGMA_BITS-1:0] sigma,
    input  logic signed [VALUE_BITS-1:0] amplitude,
    output logic signed [TERM_BITS-1:0]  term
);

    // difference and effective sigma
    logic [VALUE_BITS:0]   diff_reg;
    logic [SIGMA_BITS-1:0] sig0_reg;
    logic [VALUE_BITS:0]   diff_next;
    logic [SIGMA_BITS-1:0] sig0_next;

    assign diff_next = {abscissa[VALUE_BITS-1], abscissa} - {center[VALUE_BITS-1], center};
    assign sig0_next = (sigma == '0) ? SIGMA_BITS'(1) : sigma;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            sig0_reg <= sig0_next;
        end
    end

    // magnitude and far test
    logic [VALUE_BITS:0]   neg_diff;
    logic [VALUE_BITS-1:0] mag;
    logic                  far_next;

    assign neg_diff = ~diff_reg + 1'b1;
    assign mag      = diff_reg[VALUE_BITS] ? neg_diff[VALUE_BITS-1:0] : diff_reg[VALUE_BITS-1:0];
    assign far_next = (mag >> 3) >= VALUE_BITS'(sig0_reg);

    logic [REM_BITS-1:0] rem_reg   [0:Z_BITS];
    logic [Z_BITS-1:0]   quo_reg   [0:Z_BITS];
    div_side_t           dside_reg [0:Z_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]   <= REM_BITS'(mag);
            quo_reg[0]   <= '0;
            dside_reg[0] <= {sig0_reg, far_next};
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 0; j < Z_BITS; j++)
    begin : g_div
        localparam int SHIFT = (j < Z_INT_BITS) ? (Z_INT_BITS - 1 - j) : 0;
        logic [REM_BITS-1:0] cur;
        logic [REM_BITS-1:0] dvs;
        logic [REM_BITS:0]   trial;
        logic                ge;

        assign cur   = (j < Z_INT_BITS) ? rem_reg[j] : {rem_reg[j][REM_BITS-2:0], 1'b0};
        assign dvs   = REM_BITS'(dside_reg[j].sigma) << SHIFT;
        assign trial = {1'b0, cur} - {1'b0, dvs};
        assign ge    = ~trial[REM_BITS];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1]   <= ge ? trial[REM_BITS-1:0] : cur;
                quo_reg[j+1]   <= {quo_reg[j][Z_BITS-2:0], ge};
                dside_reg[j+1] <= dside_reg[j];
            end
        end
    end

    // square: u = z*z/2 in Q.32
    logic [2*Z_BITS-1:0] zz;
    logic [U_BITS-1:0]   u_reg;
    logic                ufar_reg;

    assign zz = quo_reg[Z_BITS] * quo_reg[Z_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= zz[2*Z_BITS-1:U_SHIFT];
            ufar_reg <= dside_reg[Z_BITS].far;
        end
    end

    // range reduction by ln2: reciprocal estimate of k is low by at most one,
    // then the remainder is formed and corrected by one compare and subtract
    logic [KU_BITS+RECIP_LN2_BITS-1:0] kp;
    logic [U_BITS-1:0]                 u1_reg;
    logic [K_BITS-1:0]                 ke_reg;
    logic                              far1_reg;
    logic [K_BITS+31:0]                kl;
    logic [U_BITS-1:0]                 r0_next;
    logic [32:0]                       r0_reg;
    logic [K_BITS-1:0]                 k1_reg;
    logic                              far2_reg;
    logic [33:0]                       rc;
    logic                              rc_ge;
    logic [31:0]                       r_reg;
    logic [K_BITS-1:0]                 k_reg;
    logic                              far3_reg;

    assign kp      = u_reg[U_BITS-1:KU_SHIFT] * RECIP_LN2;
    assign kl      = ke_reg * LN2_Q32;
    assign r0_next = u1_reg - U_BITS'(kl);
    assign rc      = {1'b0, r0_reg} - {2'b0, LN2_Q32};
    assign rc_ge   = ~rc[33];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg   <= u_reg;
            ke_reg   <= kp[KU_BITS+RECIP_LN2_BITS-1:32];
            far1_reg <= ufar_reg;
            r0_reg   <= r0_next[32:0];
            k1_reg   <= ke_reg;
            far2_reg <= far1_reg;
            r_reg    <= rc_ge ? rc[31:0] : r0_reg[31:0];
            k_reg    <= k1_reg + K_BITS'(rc_ge);
            far3_reg <= far2_reg;
        end
    end

    // horner series for exp(-r), three stages per term
    logic [E_BITS-1:0] acc_reg [1:TAYLOR_TERMS];
    series_side_t      hs_reg  [1:TAYLOR_TERMS];

    for (genvar h = 0; h < TAYLOR_TERMS; h++)
    begin : g_term
        localparam int N = TAYLOR_TERMS - h;
        localparam logic [E_BITS-1:0] RECIP = E_BITS'((65'd1 << 32) / N);

        logic [E_BITS-1:0] acc_in;
        series_side_t      side_in;
        logic [64:0]       prod_a;
        logic [31:0]       p_a_reg;
        series_side_t      s_a_reg;
        logic [64:0]       qm;
        logic [31:0]       p_b_reg;
        logic [31:0]       q0_reg;
        series_side_t      s_b_reg;
        logic [35:0]       qn;
        logic [31:0]       rem;
        logic [31:0]       q;

        if (h == 0)
        begin : g_first
            assign acc_in  = ONE_Q32;
            assign side_in = {r_reg, k_reg, far3_reg};
        end
        else
        begin : g_next
            assign acc_in  = acc_reg[h];
            assign side_in = hs_reg[h];
        end

        assign prod_a = 65'(side_in.r) * 65'(acc_in);
        assign qm     = 65'(p_a_reg) * 65'(RECIP);
        assign qn     = 36'(q0_reg) * 36'(N);
        assign rem    = p_b_reg - qn[31:0];
        assign q      = q0_reg + 32'(rem >= 32'(N));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_a_reg      <= prod_a[63:32];
                s_a_reg      <= side_in;
                p_b_reg      <= p_a_reg;
                q0_reg       <= qm[63:32];
                s_b_reg      <= s_a_reg;
                acc_reg[h+1] <= ONE_Q32 - {1'b0, q};
                hs_reg[h+1]  <= s_b_reg;
            end
        end
    end

    // scale by amplitude, round half up on the magnitude
    logic [E_BITS-1:0]     e_next;
    logic [VALUE_BITS-1:0] m_next;
    logic [E_BITS-1:0]     e_reg;
    logic [VALUE_BITS-1:0] m_reg;
    logic                  neg1_reg;
    logic [64:0]           prod_e_reg;
    logic                  neg2_reg;
    logic [64:0]           rnd;
    logic [TERM_BITS-1:0]  p_mag;
    logic signed [TERM_BITS-1:0] term_reg;

    assign e_next = hs_reg[TAYLOR_TERMS].far ? '0 : (acc_reg[TAYLOR_TERMS] >> hs_reg[TAYLOR_TERMS].k);
    assign m_next = amplitude[VALUE_BITS-1] ? (~amplitude + 1'b1) : amplitude;
    assign rnd    = prod_e_reg + (65'd1 << 31);
    assign p_mag  = rnd[64:32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_reg      <= e_next;
            m_reg      <= m_next;
            neg1_reg   <= amplitude[VALUE_BITS-1];
            prod_e_reg <= 65'(m_reg) * 65'(e_reg);
            neg2_reg   <= neg1_reg;
            term_reg   <= neg2_reg ? (~p_mag + 1'b1) : p_mag;
        end
    end

    assign term = term_reg;

endmodule

FILE: src/double_gaussian_evaluate.sv
// ---------------------------------------------------------------------------
// double_gaussian_evaluate
// sum of two gaussian peaks on a constant baseline, signed Q16.16
// ---------------------------------------------------------------------------
// Takes one abscissa per transaction and returns one result per transaction.
// Throughput is one sample per clock while the skid register is empty. The
// pipeline holds the 31-stage restoring divider that forms |t - x| / sigma
// and the 12-term exponential series (three stages per term: multiply,
// reciprocal multiply, correction). The two peaks run in parallel pipelines;
// a skid register behind the output register lets a stalled result wait
// while the pipeline keeps its contents. Registers are written through the
// config channel (always ready) and must only be changed while no sample is
// in flight.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module double_gaussian_evaluate import dge_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    dge_in_if.sink    sample,
    dge_out_if.source result,
    dge_cfg_if.sink   cfg
);

    // configuration registers
    logic [VALUE_BITS-1:0] offset_reg;
    logic [VALUE_BITS-1:0] a1_reg;
    logic [VALUE_BITS-1:0] x1_reg;
    logic [SIGMA_BITS-1:0] s1_reg;
    logic [VALUE_BITS-1:0] a2_reg;
    logic [VALUE_BITS-1:0] x2_reg;
    logic [SIGMA_BITS-1:0] s2_reg;
    logic [1:0]            sel_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= RST_BASELINE_OFFSET;
            a1_reg     <= RST_ONE_AMPLITUDE;
            x1_reg     <= RST_ONE_CENTER;
            s1_reg     <= RST_ONE_SIGMA;
            a2_reg     <= RST_TWO_AMPLITUDE;
            x2_reg     <= RST_TWO_CENTER;
            s2_reg     <= RST_TWO_SIGMA;
            sel_reg    <= RST_COMPONENT_SEL;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_BASELINE_OFFSET:    offset_reg <= cfg.data;
                REG_PEAK_ONE_AMPLITUDE: a1_reg     <= cfg.data;
                REG_PEAK_ONE_CENTER:    x1_reg     <= cfg.data;
                REG_PEAK_ONE_SIGMA:     s1_reg     <= cfg.data[SIGMA_BITS-1:0];
                REG_PEAK_TWO_AMPLITUDE: a2_reg     <= cfg.data;
                REG_PEAK_TWO_CENTER:    x2_reg     <= cfg.data;
                REG_PEAK_TWO_SIGMA:     s2_reg     <= cfg.data[SIGMA_BITS-1:0];
                REG_COMPONENT_SELECT:   sel_reg    <= cfg.data[1:0];
                default:                ; // index beyond the register list: ignored
            endcase
        end
    end

    // select bit 1 drops the first peak, bit 0 the second; code 3 leaves the offset alone
    logic signed [VALUE_BITS-1:0] amp1;
    logic signed [VALUE_BITS-1:0] amp2;

    assign amp1 = sel_reg[1] ? '0 : a1_reg;
    assign amp2 = sel_reg[0] ? '0 : a2_reg;

    // global pipeline advance: everything moves unless the skid register is occupied
    logic en;
    logic skid_valid_reg;

    assign en           = ~skid_valid_reg;
    assign sample.ready = en;

    // valid bits travel alongside the data
    logic vld_reg [0:PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= sample.valid;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // the two peak pipelines
    logic signed [TERM_BITS-1:0] term1;
    logic signed [TERM_BITS-1:0] term2;

    dge_peak u_peak_one (
        .clk       (clk),
        .en        (en),
        .abscissa  (sample.abscissa),
        .center    (x1_reg),
        .sigma     (s1_reg),
        .amplitude (amp1),
        .term      (term1)
    );

    dge_peak u_peak_two (
        .clk       (clk),
        .en        (en),
        .abscissa  (sample.abscissa),
        .center    (x2_reg),
        .sigma     (s2_reg),
        .amplitude (amp2),
        .term      (term2)
    );

    // exact three-way sum, wide enough that it cannot wrap
    logic [SUM_BITS-1:0] sum_next;
    logic [SUM_BITS-1:0] sum_reg;

    assign sum_next = {{2{offset_reg[VALUE_BITS-1]}}, offset_reg}
                    + {term1[TERM_BITS-1], term1}
                    + {term2[TERM_BITS-1], term2};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    // clip to the value range
    logic                  over_pos;
    logic                  over_neg;
    logic [VALUE_BITS-1:0] clip_value;
    logic                  clip_sat;

    assign over_pos   = ~sum_reg[SUM_BITS-1] & (sum_reg[SUM_BITS-2:VALUE_BITS-1] != '0);
    assign over_neg   = sum_reg[SUM_BITS-1] & (sum_reg[SUM_BITS-2:VALUE_BITS-1] != '1);
    assign clip_value = over_pos ? {1'b0, {(VALUE_BITS-1){1'b1}}} :
                        over_neg ? {1'b1, {(VALUE_BITS-1){1'b0}}} :
                                   sum_reg[VALUE_BITS-1:0];
    assign clip_sat   = over_pos | over_neg;

    // output register plus skid register
    logic                  deliver;
    logic                  out_free;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  skid_valid_next;
    logic                  load_out_pipe;
    logic                  load_out_skid;
    logic                  load_skid;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic                  out_sat_reg;
    logic [VALUE_BITS-1:0] skid_value_reg;
    logic                  skid_sat_reg;

    assign deliver  = en & vld_reg[PIPE_LAT-1];
    assign out_free = ~out_valid_reg | result.ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out_pipe   = 1'b0;
        load_out_skid   = 1'b0;
        load_skid       = 1'b0;
        priority if (skid_valid_reg)
        begin
            if (out_free)
            begin
                load_out_skid   = 1'b1;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (deliver)
        begin
            if (out_free)
            begin
                load_out_pipe  = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_skid)
        begin
            out_value_reg <= skid_value_reg;
            out_sat_reg   <= skid_sat_reg;
        end
        else if (load_out_pipe)
        begin
            out_value_reg <= clip_value;
            out_sat_reg   <= clip_sat;
        end
        if (load_skid)
        begin
            skid_value_reg <= clip_value;
            skid_sat_reg   <= clip_sat;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.model_value = out_value_reg;
    assign result.saturated   = out_sat_reg;

    // skid only ever holds a transaction queued behind a waiting output
    `ASSERT_IMPLIES(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)

    // a result leaving the pipeline into a blocked output is parked, not dropped
    `ASSERT_NEXT(a_no_drop, clk, rst_n, deliver && out_valid_reg && !result.ready, skid_valid_reg)

    // a flagged result sits on one of the two range limits
    `ASSERT_IMPLIES(a_sat_at_limit, clk, rst_n, result.valid && result.saturated, result.model_value == {1'b0, {(VALUE_BITS-1){1'b1}}} || result.model_value == {1'b1, {(VALUE_BITS-1){1'b0}}})

endmodule
